// ===== rtl/batb_pkg.sv =====
// Shared constants, widths and control/status structs for the Bezier angle table builder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package batb_pkg;

    // Table and point store geometry
    localparam int TABLE_SIZE = 32;
    localparam int HALF_TABLE = TABLE_SIZE / 2;
    localparam int PT_STORE_DEPTH = 16;
    localparam int TIDX_W     = $clog2(TABLE_SIZE);
    localparam int PIDX_W     = $clog2(PT_STORE_DEPTH);
    localparam int PCNT_W     = PIDX_W + 1;

    // Field widths
    localparam int COORD_W    = 16;
    localparam int COORD_FRAC = 15;
    localparam int ANG_W      = 16;
    localparam int OUT_IDX_W  = 6;

    // Oversample register; sizing covers every value the 5-bit field can hold
    localparam int             OS_W     = 5;
    localparam int             OS_MAX   = (1 << OS_W) - 1;
    localparam logic [OS_W-1:0] OS_RESET = 5'd10;

    // Sample count per segment and its powers
    localparam int MMAX  = TABLE_SIZE * OS_MAX;
    localparam int M_W   = $clog2(MMAX + 1);
    localparam int M2_W  = $clog2(MMAX * MMAX + 1);
    localparam int M3_W  = $clog2(MMAX * MMAX * MMAX + 1);

    // Accumulators of the weighted sums
    localparam int NX_W  = M3_W + COORD_W;
    localparam int NY_W  = M3_W + ANG_W + 1;

    // Sample index (floor of x*(TABLE_SIZE-1)) stays below 2*TABLE_SIZE
    localparam int SIDX_W = TIDX_W + 1;
    localparam int LW_W   = SIDX_W + 1;

    // Shared divider; the index dividend needs one bit more for coordinates above 1.0
    localparam int Q_W       = ANG_W;
    localparam int DIV_CNT_W = $clog2(Q_W + 1);
    localparam int IDX_SHIFT = COORD_FRAC + SIDX_W - 1;
    localparam int DIV_W     = M3_W + IDX_SHIFT + 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store_point;
        logic clr_joint;
        logic calc_m2;
        logic calc_m3;
        logic seg_init;
        logic seg_next;
        logic j_init;
        logic load_rd;
        logic load_cap;
        logic k_init;
        logic k_next;
        logic sq;
        logic cu;
        logic wgt;
        logic mul;
        logic acc;
        logic div_start_idx;
        logic div_start_ang;
        logic idx_cap;
        logic tbl_write;
        logic emit_init;
        logic emit_rd;
        logic emit_load;
        logic emit_next;
    } batb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic seg_avail;
        logic j_last;
        logic k_last;
        logic div_done;
        logic idx_gt;
        logic emit_last;
        logic out_valid;
        logic out_taken;
    } batb_sts_t;

endpackage

// ===== rtl/bezier_angle_table_builder_unit.sv =====
// Top level of the Bezier joint-angle table builder.
// Depends on batb_pkg, batb_ctrl, batb_dpath and batb_div.
`timescale 1ns / 1ps

// Usage:
// Control points of one joint come in on the input channel (in_valid/in_stall),
// one item each: phase_coord, joint_angle and last_point. A point that is not
// last is stored; points beyond sixteen are dropped. The point
// marked last_point starts the build: every full cubic segment (points 0..3,
// 3..6, ...) has its four points loaded and is then sampled at 32*oversample+1
// values of t. Each sample runs weight and sum arithmetic, then the 6-bit table
// index through the shared bit-serial divider, then a compare and advance; a
// sample that writes an entry also runs the 16-bit angle division, and a joint
// writes at most 62 entries. Then 32 items (table_index, left_angle,
// right_angle, end_of_table) leave on the output channel (out_valid/out_stall);
// each item is read from the table, loaded and held until taken before the next
// is read, so a stall holds the current item and pauses emission. in_stall stays
// high from the last point until the final item is taken. oversample is to be
// written through cfg_valid/cfg_ready/cfg_data only while the block is idle; the
// block does not enforce this. Reset empties the point store and table, sets 10.

module bezier_angle_table_builder_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [batb_pkg::COORD_W-1:0]         phase_coord,
    input  logic signed [batb_pkg::ANG_W-1:0]    joint_angle,
    input  logic                                 last_point,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [batb_pkg::OUT_IDX_W-1:0]       table_index,
    output logic signed [batb_pkg::ANG_W-1:0]    left_angle,
    output logic signed [batb_pkg::ANG_W-1:0]    right_angle,
    output logic                                 end_of_table,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [batb_pkg::OS_W-1:0]            cfg_data
);

    batb_pkg::batb_cmd_t                cmd;
    batb_pkg::batb_sts_t                sts;
    logic [batb_pkg::DIV_W-1:0]         div_dividend;
    logic [batb_pkg::DIV_W-1:0]         div_divisor;
    logic [batb_pkg::DIV_CNT_W-1:0]     div_nbits;
    logic [batb_pkg::Q_W-1:0]           div_quot;
    logic                               div_done;
    logic                               div_start;

    // Register writes are always taken
    assign cfg_ready = 1'b1;
    assign div_start = cmd.div_start_idx || cmd.div_start_ang;

    batb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_point (last_point),
        .in_stall   (in_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    batb_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .phase_coord  (phase_coord),
        .joint_angle  (joint_angle),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_nbits    (div_nbits),
        .div_quot     (div_quot),
        .div_done     (div_done),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .table_index  (table_index),
        .left_angle   (left_angle),
        .right_angle  (right_angle),
        .end_of_table (end_of_table)
    );

    batb_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (div_dividend),
        .divisor_top (div_divisor),
        .nbits       (div_nbits),
        .quot        (div_quot),
        .done        (div_done)
    );

endmodule

// ===== rtl/batb_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by index and angle computation.
// Depends on batb_pkg.
`timescale 1ns / 1ps

module batb_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [batb_pkg::DIV_W-1:0]         dividend,
    input  logic [batb_pkg::DIV_W-1:0]         divisor_top,
    input  logic [batb_pkg::DIV_CNT_W-1:0]     nbits,
    output logic [batb_pkg::Q_W-1:0]           quot,
    output logic                               done
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [batb_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [batb_pkg::DIV_W-1:0]         rem_reg;
    logic [batb_pkg::DIV_W-1:0]         dsr_reg;
    logic [batb_pkg::Q_W-1:0]           q_reg;
    logic                               ge;

    // Trial subtract of the current divisor position
    assign ge = (rem_reg >= dsr_reg);

    // Control: busy flag, step count, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - batb_pkg::DIV_CNT_W'(1);
                if (cnt_reg == batb_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, shifting divisor, quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsr_reg <= divisor_top;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg <= dsr_reg >> 1;
            q_reg   <= {q_reg[batb_pkg::Q_W-2:0], ge};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

    // A new division never starts over one in flight
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // Done is reported only once the unit has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

endmodule

// ===== rtl/batb_dpath.sv =====
// Datapath: point store, Bernstein weights, weighted sums, angle table and output register.
// Depends on batb_pkg; driven by batb_ctrl commands, uses batb_div for the two divisions.
`timescale 1ns / 1ps

module batb_dpath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  batb_pkg::batb_cmd_t                  cmd,
    output batb_pkg::batb_sts_t                  sts,
    input  logic                                 cfg_we,
    input  logic [batb_pkg::OS_W-1:0]            cfg_data,
    input  logic [batb_pkg::COORD_W-1:0]         phase_coord,
    input  logic signed [batb_pkg::ANG_W-1:0]    joint_angle,
    output logic [batb_pkg::DIV_W-1:0]           div_dividend,
    output logic [batb_pkg::DIV_W-1:0]           div_divisor,
    output logic [batb_pkg::DIV_CNT_W-1:0]       div_nbits,
    input  logic [batb_pkg::Q_W-1:0]             div_quot,
    input  logic                                 div_done,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [batb_pkg::OUT_IDX_W-1:0]       table_index,
    output logic signed [batb_pkg::ANG_W-1:0]    left_angle,
    output logic signed [batb_pkg::ANG_W-1:0]    right_angle,
    output logic                                 end_of_table
);

    // Configuration and joint state
    logic [batb_pkg::OS_W-1:0]          os_reg;
    logic [batb_pkg::PCNT_W-1:0]        count_reg;
    logic signed [batb_pkg::LW_W-1:0]   lw_reg;

    // Point store
    logic [batb_pkg::COORD_W-1:0]       pt_coord_mem [batb_pkg::PT_STORE_DEPTH];
    logic [batb_pkg::ANG_W-1:0]         pt_angle_mem [batb_pkg::PT_STORE_DEPTH];
    logic [batb_pkg::COORD_W-1:0]       pt_c_rd_reg;
    logic [batb_pkg::ANG_W-1:0]         pt_a_rd_reg;
    logic [batb_pkg::PIDX_W-1:0]        pt_rd_addr;

    // Segment and sample state
    logic [batb_pkg::PCNT_W-1:0]        p_reg;
    logic [1:0]                         j_reg;
    logic [batb_pkg::M_W-1:0]           k_reg;
    logic [batb_pkg::COORD_W-1:0]       seg_c_reg [4];
    logic signed [batb_pkg::ANG_W-1:0]  seg_a_reg [4];

    // Arithmetic pipeline registers
    logic [batb_pkg::M2_W-1:0]          mm_reg;
    logic [batb_pkg::M3_W-1:0]          m3_reg;
    logic [batb_pkg::M2_W-1:0]          uu_reg;
    logic [batb_pkg::M2_W-1:0]          kk_reg;
    logic [batb_pkg::M3_W-1:0]          t_reg [4];
    logic [batb_pkg::M3_W-1:0]          w_reg [4];
    logic [batb_pkg::NX_W-1:0]          prodx_reg;
    logic signed [batb_pkg::NY_W-1:0]   prody_reg;
    logic [batb_pkg::NX_W-1:0]          accx_reg;
    logic signed [batb_pkg::NY_W-1:0]   accy_reg;
    logic [batb_pkg::SIDX_W-1:0]        idx_reg;

    // Angle table with per-entry valid bits
    logic [batb_pkg::ANG_W-1:0]         tbl_mem [batb_pkg::TABLE_SIZE];
    logic [batb_pkg::TABLE_SIZE-1:0]    tv_reg;
    logic [batb_pkg::ANG_W-1:0]         tl_rd_reg;
    logic [batb_pkg::ANG_W-1:0]         tr_rd_reg;
    logic [batb_pkg::TIDX_W-1:0]        emit_i_reg;

    // Output register
    logic                               out_valid_reg;
    logic [batb_pkg::OUT_IDX_W-1:0]     out_idx_reg;
    logic [batb_pkg::ANG_W-1:0]         out_l_reg;
    logic [batb_pkg::ANG_W-1:0]         out_r_reg;
    logic                               out_end_reg;

    // Combinational helpers
    logic [batb_pkg::OS_W-1:0]          os_eff;
    logic [batb_pkg::M_W-1:0]           m_val;
    logic [batb_pkg::M_W-1:0]           u_val;
    logic [batb_pkg::PCNT_W:0]          seg_end;
    logic [batb_pkg::TIDX_W:0]          wr_full;
    logic [batb_pkg::TIDX_W-1:0]        wr_addr;
    logic [batb_pkg::TIDX_W:0]          part_full;
    logic [batb_pkg::TIDX_W-1:0]        part_addr;
    logic [batb_pkg::NY_W-1:0]          ny_off;
    logic [batb_pkg::DIV_W-1:0]         ang_dividend;
    logic [batb_pkg::DIV_W-1:0]         idx_dividend;
    logic [batb_pkg::ANG_W-1:0]         ang_val;
    logic                               out_taken;

    // Samples per segment; zero oversample acts as one
    assign os_eff = (os_reg == '0) ? batb_pkg::OS_W'(1) : os_reg;
    assign m_val  = batb_pkg::M_W'(os_eff) * batb_pkg::M_W'(batb_pkg::TABLE_SIZE);
    assign u_val  = m_val - k_reg;

    // A segment needs four stored points from p
    assign seg_end = {1'b0, p_reg} + (batb_pkg::PCNT_W + 1)'(3);

    assign pt_rd_addr = batb_pkg::PIDX_W'(p_reg + batb_pkg::PCNT_W'(j_reg));

    // Table write address is the sample index folded into the table
    assign wr_full = batb_pkg::TIDX_W'(0) + idx_reg;
    assign wr_addr = (idx_reg >= batb_pkg::SIDX_W'(batb_pkg::TABLE_SIZE))
                   ? batb_pkg::TIDX_W'(wr_full - (batb_pkg::TIDX_W + 1)'(batb_pkg::TABLE_SIZE))
                   : batb_pkg::TIDX_W'(wr_full);

    // Out-of-phase partner entry
    assign part_full = {1'b0, emit_i_reg} + (batb_pkg::TIDX_W + 1)'(batb_pkg::HALF_TABLE);
    assign part_addr = (part_full >= (batb_pkg::TIDX_W + 1)'(batb_pkg::TABLE_SIZE))
                     ? batb_pkg::TIDX_W'(part_full - (batb_pkg::TIDX_W + 1)'(batb_pkg::TABLE_SIZE))
                     : batb_pkg::TIDX_W'(part_full);

    // Divider operands: angle is offset to be nonnegative, then rounded half up
    assign ny_off       = $unsigned(accy_reg)
                        + (batb_pkg::NY_W'(m3_reg) << batb_pkg::COORD_FRAC);
    assign ang_dividend = batb_pkg::DIV_W'({ny_off, 1'b0}) + batb_pkg::DIV_W'(m3_reg);
    assign idx_dividend = batb_pkg::DIV_W'(accx_reg)
                        * batb_pkg::DIV_W'(batb_pkg::TABLE_SIZE - 1);

    always_comb
    begin
        if (cmd.div_start_ang)
        begin
            div_dividend = ang_dividend;
            div_divisor  = batb_pkg::DIV_W'(m3_reg) << batb_pkg::Q_W;
            div_nbits    = batb_pkg::DIV_CNT_W'(batb_pkg::Q_W);
        end
        else
        begin
            div_dividend = idx_dividend;
            div_divisor  = batb_pkg::DIV_W'(m3_reg) << batb_pkg::IDX_SHIFT;
            div_nbits    = batb_pkg::DIV_CNT_W'(batb_pkg::SIDX_W);
        end
    end

    // Undo the offset of the angle quotient
    assign ang_val = {~div_quot[batb_pkg::Q_W-1], div_quot[batb_pkg::Q_W-2:0]};

    assign out_taken = out_valid_reg && !out_stall;

    // Status back to the controller
    always_comb
    begin
        sts.seg_avail = (seg_end < (batb_pkg::PCNT_W + 1)'(count_reg));
        sts.j_last    = (j_reg == 2'd3);
        sts.k_last    = (k_reg == m_val);
        sts.div_done  = div_done;
        sts.idx_gt    = ($signed({1'b0, idx_reg}) > lw_reg);
        sts.emit_last = (emit_i_reg == batb_pkg::TIDX_W'(batb_pkg::TABLE_SIZE - 1));
        sts.out_valid = out_valid_reg;
        sts.out_taken = out_taken;
    end

    // Control registers: config, fill count, last written, counters, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            os_reg        <= batb_pkg::OS_RESET;
            count_reg     <= '0;
            lw_reg        <= '1;
            tv_reg        <= '0;
            p_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            emit_i_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                os_reg <= cfg_data;
            end
            if (cmd.clr_joint)
            begin
                count_reg <= '0;
                lw_reg    <= '1;
                tv_reg    <= '0;
            end
            else
            begin
                if (cmd.store_point
                    && (count_reg < batb_pkg::PCNT_W'(batb_pkg::PT_STORE_DEPTH)))
                begin
                    count_reg <= count_reg + batb_pkg::PCNT_W'(1);
                end
                if (cmd.tbl_write)
                begin
                    lw_reg          <= lw_reg + batb_pkg::LW_W'(1);
                    tv_reg[wr_addr] <= 1'b1;
                end
            end
            if (cmd.seg_init)
            begin
                p_reg <= '0;
            end
            else if (cmd.seg_next)
            begin
                p_reg <= p_reg + batb_pkg::PCNT_W'(3);
            end
            if (cmd.j_init)
            begin
                j_reg <= '0;
            end
            else if (cmd.load_cap || cmd.acc)
            begin
                j_reg <= j_reg + 2'd1;
            end
            if (cmd.k_init)
            begin
                k_reg <= '0;
            end
            else if (cmd.k_next)
            begin
                k_reg <= k_reg + batb_pkg::M_W'(1);
            end
            if (cmd.emit_init)
            begin
                emit_i_reg <= '0;
            end
            else if (cmd.emit_next)
            begin
                emit_i_reg <= emit_i_reg + batb_pkg::TIDX_W'(1);
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Point store: write at the fill count, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.store_point && (count_reg < batb_pkg::PCNT_W'(batb_pkg::PT_STORE_DEPTH)))
        begin
            pt_coord_mem[count_reg[batb_pkg::PIDX_W-1:0]] <= phase_coord;
            pt_angle_mem[count_reg[batb_pkg::PIDX_W-1:0]] <= joint_angle;
        end
        if (cmd.load_rd)
        begin
            pt_c_rd_reg <= pt_coord_mem[pt_rd_addr];
            pt_a_rd_reg <= pt_angle_mem[pt_rd_addr];
        end
    end

    // Arithmetic: powers of M, weights, products and sums
    always_ff @(posedge clk)
    begin
        if (cmd.calc_m2)
        begin
            mm_reg <= batb_pkg::M2_W'(m_val) * batb_pkg::M2_W'(m_val);
        end
        if (cmd.calc_m3)
        begin
            m3_reg <= batb_pkg::M3_W'(mm_reg) * batb_pkg::M3_W'(m_val);
        end
        if (cmd.load_cap)
        begin
            seg_c_reg[j_reg] <= pt_c_rd_reg;
            seg_a_reg[j_reg] <= pt_a_rd_reg;
        end
        if (cmd.sq)
        begin
            uu_reg <= batb_pkg::M2_W'(u_val) * batb_pkg::M2_W'(u_val);
            kk_reg <= batb_pkg::M2_W'(k_reg) * batb_pkg::M2_W'(k_reg);
        end
        if (cmd.cu)
        begin
            t_reg[0] <= batb_pkg::M3_W'(uu_reg) * batb_pkg::M3_W'(u_val);
            t_reg[1] <= batb_pkg::M3_W'(uu_reg) * batb_pkg::M3_W'(k_reg);
            t_reg[2] <= batb_pkg::M3_W'(kk_reg) * batb_pkg::M3_W'(u_val);
            t_reg[3] <= batb_pkg::M3_W'(kk_reg) * batb_pkg::M3_W'(k_reg);
        end
        // Inner weights carry the binomial factor three
        if (cmd.wgt)
        begin
            w_reg[0] <= t_reg[0];
            w_reg[1] <= (t_reg[1] << 1) + t_reg[1];
            w_reg[2] <= (t_reg[2] << 1) + t_reg[2];
            w_reg[3] <= t_reg[3];
            accx_reg <= '0;
            accy_reg <= '0;
        end
        if (cmd.mul)
        begin
            prodx_reg <= batb_pkg::NX_W'(w_reg[j_reg]) * batb_pkg::NX_W'(seg_c_reg[j_reg]);
            prody_reg <= $signed(batb_pkg::NY_W'(w_reg[j_reg]))
                       * $signed({{(batb_pkg::NY_W - batb_pkg::ANG_W)
                                    {seg_a_reg[j_reg][batb_pkg::ANG_W-1]}},
                                  seg_a_reg[j_reg]});
        end
        if (cmd.acc)
        begin
            accx_reg <= accx_reg + prodx_reg;
            accy_reg <= accy_reg + prody_reg;
        end
        if (cmd.idx_cap)
        begin
            idx_reg <= div_quot[batb_pkg::SIDX_W-1:0];
        end
    end

    // Angle table: one write port, two registered reads masked by valid bits
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write)
        begin
            tbl_mem[wr_addr] <= ang_val;
        end
        if (cmd.emit_rd)
        begin
            tl_rd_reg <= tv_reg[emit_i_reg] ? tbl_mem[emit_i_reg] : '0;
            tr_rd_reg <= tv_reg[part_addr] ? tbl_mem[part_addr] : '0;
        end
    end

    // Output payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_idx_reg <= batb_pkg::OUT_IDX_W'(emit_i_reg);
            out_l_reg   <= tl_rd_reg;
            out_r_reg   <= tr_rd_reg;
            out_end_reg <= sts.emit_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign table_index  = out_idx_reg;
    assign left_angle   = $signed(out_l_reg);
    assign right_angle  = $signed(out_r_reg);
    assign end_of_table = out_end_reg;

    // Each table write advances last-written by exactly one
    a_lw_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_write |=> lw_reg == $past(lw_reg) + batb_pkg::LW_W'(1))
        else $error("last written did not advance on table write");

    // Table is written only for an index beyond the last written one
    a_wr_gt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_write |-> sts.idx_gt)
        else $error("table write with stale index");

endmodule

// ===== rtl/batb_ctrl.sv =====
// Controller state machine: sequences point loading, segment sampling, divisions and emission.
// Depends on batb_pkg; drives batb_dpath and batb_div through the command struct.
`timescale 1ns / 1ps

module batb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last_point,
    output logic                 in_stall,
    input  batb_pkg::batb_sts_t  sts,
    output batb_pkg::batb_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_M2   = 5'd1;
    localparam logic [4:0] S_M3   = 5'd2;
    localparam logic [4:0] S_SEG  = 5'd3;
    localparam logic [4:0] S_LRD  = 5'd4;
    localparam logic [4:0] S_LCAP = 5'd5;
    localparam logic [4:0] S_SQ   = 5'd6;
    localparam logic [4:0] S_CU   = 5'd7;
    localparam logic [4:0] S_WGT  = 5'd8;
    localparam logic [4:0] S_MUL  = 5'd9;
    localparam logic [4:0] S_ACC  = 5'd10;
    localparam logic [4:0] S_DIX  = 5'd11;
    localparam logic [4:0] S_WIX  = 5'd12;
    localparam logic [4:0] S_CMP  = 5'd13;
    localparam logic [4:0] S_DAN  = 5'd14;
    localparam logic [4:0] S_WAN  = 5'd15;
    localparam logic [4:0] S_KN   = 5'd16;
    localparam logic [4:0] S_ERD  = 5'd17;
    localparam logic [4:0] S_ELD  = 5'd18;
    localparam logic [4:0] S_EWT  = 5'd19;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       accept;

    // Take items only between joints' builds
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.store_point = accept;
                if (accept && last_point)
                begin
                    state_next = S_M2;
                end
            end
            S_M2:
            begin
                cmd.calc_m2 = 1'b1;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.calc_m3  = 1'b1;
                cmd.seg_init = 1'b1;
                state_next   = S_SEG;
            end
            S_SEG:
            begin
                if (sts.seg_avail)
                begin
                    cmd.j_init = 1'b1;
                    state_next = S_LRD;
                end
                else
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = S_ERD;
                end
            end
            S_LRD:
            begin
                cmd.load_rd = 1'b1;
                state_next  = S_LCAP;
            end
            S_LCAP:
            begin
                cmd.load_cap = 1'b1;
                if (sts.j_last)
                begin
                    cmd.k_init = 1'b1;
                    state_next = S_SQ;
                end
                else
                begin
                    state_next = S_LRD;
                end
            end
            S_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = S_CU;
            end
            S_CU:
            begin
                cmd.cu     = 1'b1;
                state_next = S_WGT;
            end
            S_WGT:
            begin
                cmd.wgt    = 1'b1;
                cmd.j_init = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.j_last ? S_DIX : S_MUL;
            end
            S_DIX:
            begin
                cmd.div_start_idx = 1'b1;
                state_next        = S_WIX;
            end
            S_WIX:
            begin
                if (sts.div_done)
                begin
                    cmd.idx_cap = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = sts.idx_gt ? S_DAN : S_KN;
            end
            S_DAN:
            begin
                cmd.div_start_ang = 1'b1;
                state_next        = S_WAN;
            end
            S_WAN:
            begin
                if (sts.div_done)
                begin
                    cmd.tbl_write = 1'b1;
                    state_next    = S_KN;
                end
            end
            S_KN:
            begin
                if (sts.k_last)
                begin
                    cmd.seg_next = 1'b1;
                    state_next   = S_SEG;
                end
                else
                begin
                    cmd.k_next = 1'b1;
                    state_next = S_SQ;
                end
            end
            S_ERD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_ELD;
            end
            S_ELD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = S_EWT;
            end
            S_EWT:
            begin
                if (sts.out_taken)
                begin
                    if (sts.emit_last)
                    begin
                        cmd.clr_joint = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output register is empty whenever a new entry is loaded
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> !sts.out_valid)
        else $error("output entry overwritten");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for bezier_angle_table_builder_unit: joints of control points
// are driven with random idling, each emitted table is checked against an integer curve
// predictor or a directed constant table. Depends on batb_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [batb_pkg::OUT_IDX_W-1:0]    idx;
        logic signed [batb_pkg::ANG_W-1:0] left;
        logic signed [batb_pkg::ANG_W-1:0] right;
        logic                              eot;
    } table_entry_t;

    // Directed row: one control point; on a last point, kind_const asks for a table
    // filled with const_ang instead of the predictor's table
    typedef struct {
        int  coord;
        int  ang;
        bit  last;
        bit  kind_const;
        int  const_ang;
    } point_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [batb_pkg::COORD_W-1:0]      phase_coord;
    logic signed [batb_pkg::ANG_W-1:0] joint_angle;
    logic                              last_point;
    logic                              out_valid;
    logic                              out_stall;
    logic [batb_pkg::OUT_IDX_W-1:0]    table_index;
    logic signed [batb_pkg::ANG_W-1:0] left_angle;
    logic signed [batb_pkg::ANG_W-1:0] right_angle;
    logic                              end_of_table;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [batb_pkg::OS_W-1:0]         cfg_data;

    bezier_angle_table_builder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .phase_coord  (phase_coord),
        .joint_angle  (joint_angle),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .table_index  (table_index),
        .left_angle   (left_angle),
        .right_angle  (right_angle),
        .end_of_table (end_of_table),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Predictor state
    int           os_reg;
    longint       pt_coord [batb_pkg::PT_STORE_DEPTH];
    longint       pt_ang   [batb_pkg::PT_STORE_DEPTH];
    int           pt_cnt;
    longint       ang_tab  [batb_pkg::TABLE_SIZE];
    longint       last_idx;
    table_entry_t pending_entries[$];

    int  errors;
    bit  quiet;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit
    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 11);
    endfunction

    function automatic longint floor_quot(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q--;
        return q;
    endfunction

    // Sample one cubic segment starting at point base into the angle table
    function automatic void sample_segment(int base, longint m);
        longint m3, u, nx, ny, idx;
        longint w[4];
        m3 = m * m * m;
        for (longint k = 0; k <= m; k++)
        begin
            u = m - k;
            w[0] = u * u * u;
            w[1] = 3 * u * u * k;
            w[2] = 3 * u * k * k;
            w[3] = k * k * k;
            nx = 0;
            ny = 0;
            for (int j = 0; j < 4; j++)
            begin
                nx += w[j] * pt_coord[base + j];
                ny += w[j] * pt_ang[base + j];
            end
            idx = (nx * (batb_pkg::TABLE_SIZE - 1)) / (m3 * 32768);
            if (idx > last_idx)
            begin
                ang_tab[idx % batb_pkg::TABLE_SIZE] = floor_quot(2 * ny + m3, 2 * m3);
                last_idx++;
            end
        end
    endfunction

    // Store one point; on the last point build and queue the whole table
    function automatic void predict_point(int coord, int ang, bit last);
        longint m;
        table_entry_t e;
        if (pt_cnt < batb_pkg::PT_STORE_DEPTH)
        begin
            pt_coord[pt_cnt] = coord;
            pt_ang[pt_cnt]   = ang;
            pt_cnt++;
        end
        if (!last)
            return;
        m = batb_pkg::TABLE_SIZE * ((os_reg == 0) ? 1 : os_reg);
        for (int p = 0; p + 3 < pt_cnt; p += 3)
            sample_segment(p, m);
        for (int i = 0; i < batb_pkg::TABLE_SIZE; i++)
        begin
            e.idx   = batb_pkg::OUT_IDX_W'(i);
            e.left  = batb_pkg::ANG_W'(ang_tab[i]);
            e.right = batb_pkg::ANG_W'(ang_tab[(i + batb_pkg::HALF_TABLE)
                                               % batb_pkg::TABLE_SIZE]);
            e.eot   = (i == batb_pkg::TABLE_SIZE - 1);
            pending_entries.push_back(e);
        end
        pt_cnt   = 0;
        last_idx = -1;
        foreach (ang_tab[i])
            ang_tab[i] = 0;
    endfunction

    // Drive one point and wait for it to be taken
    task automatic send_point(int coord, int ang, bit last);
        while (idle_roll())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        phase_coord <= coord[batb_pkg::COORD_W-1:0];
        joint_angle <= ang[batb_pkg::ANG_W-1:0];
        last_point  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_point(coord, ang, last);
        @(negedge clk);
    endtask

    // Write oversample once the block has drained
    task automatic write_oversample(int value);
        in_valid <= 1'b0;
        while (pending_entries.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[batb_pkg::OS_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        os_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random joint: mostly whole segments with rising coordinates, some noise
    task automatic random_joint(int max_len, output int n_sent);
        int n;
        int coords[$];
        bit orderly;
        orderly = ($urandom_range(99) < 75);
        if (orderly)
            n = 3 * $urandom_range((max_len - 1) / 3, 1) + 1;
        else
            n = $urandom_range(max_len, 1);
        for (int i = 0; i < n; i++)
            coords.push_back($urandom_range(32768));
        if (orderly)
        begin
            coords.sort();
            if ($urandom_range(1))
            begin
                coords[0]     = 0;
                coords[n - 1] = 32768;
            end
        end
        for (int i = 0; i < n; i++)
            send_point(coords[i], $signed(16'($urandom)), i == n - 1);
        n_sent = n;
    endtask

    // Output side: random stall at the falling edge
    always @(negedge clk)
        if (rst_n)
            out_stall <= idle_roll();

    // Check each taken item against the oldest expectation
    always @(posedge clk)
    begin
        table_entry_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_entries.size() == 0)
            begin
                $error("unexpected item table_index=%0d", table_index);
                errors++;
            end
            else
            begin
                e = pending_entries.pop_front();
                if (table_index !== e.idx)
                begin
                    $error("table_index expected %0d actual %0d", e.idx, table_index);
                    errors++;
                end
                if (left_angle !== e.left)
                begin
                    $error("left_angle expected %0d actual %0d", e.left, left_angle);
                    errors++;
                end
                if (right_angle !== e.right)
                begin
                    $error("right_angle expected %0d actual %0d", e.right, right_angle);
                    errors++;
                end
                if (end_of_table !== e.eot)
                begin
                    $error("end_of_table expected %0d actual %0d", e.eot, end_of_table);
                    errors++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        point_row_t rows[$];
        int os_list[$];
        table_entry_t e;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        phase_coord = '0;
        joint_angle = '0;
        last_point  = 1'b0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        errors      = 0;
        quiet       = 1'b0;
        os_reg      = batb_pkg::OS_RESET;
        pt_cnt      = 0;
        last_idx    = -1;
        foreach (ang_tab[i])
            ang_tab[i] = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: short joints, flat tables at both angle extremes, crossing extremes
        rows = '{
            '{12000, 500, 0, 0, 0}, '{20000, -700, 0, 0, 0}, '{32768, 900, 1, 1, 0},
            '{32768, 32767, 1, 1, 0},
            '{0, 32767, 0, 0, 0}, '{10923, 32767, 0, 0, 0}, '{21845, 32767, 0, 0, 0},
            '{32768, 32767, 1, 1, 32767},
            '{0, -32768, 0, 0, 0}, '{10923, -32768, 0, 0, 0}, '{21845, -32768, 0, 0, 0},
            '{32768, -32768, 1, 1, -32768},
            '{32768, -32768, 0, 0, 0}, '{0, 32767, 0, 0, 0}, '{32768, -32768, 0, 0, 0},
            '{0, 32767, 1, 0, 0},
            '{0, -1, 0, 0, 0}, '{16384, 1, 0, 0, 0}, '{16384, -1, 0, 0, 0},
            '{32768, 1, 0, 0, 0}, '{32767, 255, 0, 0, 0}, '{32768, -255, 0, 0, 0},
            '{32768, 100, 1, 0, 0}
        };
        foreach (rows[r])
        begin
            send_point(rows[r].coord, rows[r].ang, rows[r].last);
            // Replace the predicted table with the one read off directly
            if (rows[r].last && rows[r].kind_const)
            begin
                repeat (batb_pkg::TABLE_SIZE) void'(pending_entries.pop_back());
                for (int i = 0; i < batb_pkg::TABLE_SIZE; i++)
                begin
                    e.idx   = batb_pkg::OUT_IDX_W'(i);
                    e.left  = batb_pkg::ANG_W'(rows[r].const_ang);
                    e.right = batb_pkg::ANG_W'(rows[r].const_ang);
                    e.eot   = (i == batb_pkg::TABLE_SIZE - 1);
                    pending_entries.push_back(e);
                end
            end
        end

        // Random phases over several oversample settings
        os_list = '{1, 16, 0, 15, 2, 3, 10};
        foreach (os_list[ph])
        begin
            int sent;
            int n_pts;
            write_oversample(os_list[ph]);
            quiet = (ph == 3);
            sent  = 0;
            while (sent < 22)
            begin
                random_joint((os_list[ph] >= 10) ? 7 : 20, n_pts);
                sent += n_pts;
            end
        end
        quiet    = 1'b0;
        in_valid <= 1'b0;

        while (pending_entries.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/batb_pkg.sv
rtl/batb_div.sv
rtl/batb_dpath.sv
rtl/batb_ctrl.sv
rtl/bezier_angle_table_builder_unit.sv
tb/testbench.sv
